>>> rtl/first_fit_block_allocator_assert.svh
// Assertion macros used by the allocator top level.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define FFBA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

    localparam int OFF_W   = 33;
    localparam int ADDR_W  = 40;
    localparam int SIZE_W  = 32;
    localparam int ALIGN_W = 17;
    localparam int RND_W   = 34;
    localparam int STAT_W  = 2;
    localparam int TYPE_W  = 2;
    localparam int IN_W    = 96;
    localparam int OUT_W   = 112;
    localparam int CFG_IDX_W = 1;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [ADDR_W-1:0] REGION_BASE_RST = 40'd4096;
    localparam logic [OFF_W-1:0]  POOL_CAP_RST    = 33'd1073741824;

    // Request kinds.
    localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOSPACE  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_CAP    = 1'd1;

    // One table entry as stored in the block table memory.
    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [OFF_W-1:0] length;
        logic             is_free;
    } entry_t;

endpackage
`default_nettype wire

>>> rtl/ffba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/ffba_round.sv
// Rounds a size up to a multiple of the alignment with a bit-serial remainder unit.
`default_nettype none
module ffba_round (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ffba_pkg::SIZE_W-1:0]   size,
    input  wire logic [ffba_pkg::ALIGN_W-1:0]  align,
    output logic                               done,
    output logic      [ffba_pkg::RND_W-1:0]    rounded
);
    import ffba_pkg::*;

    localparam int CNT_W = $clog2(RND_W);

    logic [RND_W-1:0]   n_reg, n_next;
    logic [RND_W-1:0]   shift_reg, shift_next;
    logic [ALIGN_W-1:0] align_reg, align_next;
    logic [ALIGN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [ALIGN_W-1:0] align_eff;
    logic [ALIGN_W:0]   trial;

    // A zero alignment behaves as alignment one.
    assign align_eff = (align == '0) ? ALIGN_W'(1) : align;
    assign trial     = {rem_reg, shift_reg[RND_W-1]};

    // One restoring-division step per cycle on n = size + align - 1.
    always_comb
    begin
        n_next     = n_reg;
        shift_next = shift_reg;
        align_next = align_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (start)
        begin
            n_next     = RND_W'(size) + RND_W'(align_eff) - RND_W'(1);
            shift_next = RND_W'(size) + RND_W'(align_eff) - RND_W'(1);
            align_next = align_eff;
            rem_next   = '0;
            cnt_next   = '0;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, align_reg})
            begin
                rem_next = ALIGN_W'(trial - {1'b0, align_reg});
            end
            else
            begin
                rem_next = trial[ALIGN_W-1:0];
            end
            shift_next = {shift_reg[RND_W-2:0], 1'b0};
            cnt_next   = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(RND_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        shift_reg <= shift_next;
        align_reg <= align_next;
        rem_reg   <= rem_next;
    end

    assign done    = done_reg;
    assign rounded = n_reg - RND_W'(rem_reg);

endmodule
`default_nettype wire

>>> rtl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator with split and coalesce.
//
// Requests arrive as words on the s_axis channel and each one yields exactly
// one result word on the m_axis channel. Registers region_base and
// pool_capacity are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while the block is idle; the block does not enforce it.
// The block works on one request at a time and deasserts s_axis_tready
// from acceptance until its result is loaded into the output register.
// Clear and the immediate error cases go straight to the result. Allocate runs
// the remainder unit, then scans the table entries, then writes one or two
// entries. Free scans the table, then insertion-sorts it by offset through
// the single table memory port pair, then walks it to merge runs of
// adjacent free blocks. Reset empties the table and clears the reserved and
// peak totals; the table memory itself is not cleared. When the receiver
// stalls, the result waits in the output register and the next request is
// still accepted; its own result then waits until that register is free.
`default_nettype none
`include "first_fit_block_allocator_assert.svh"
module first_fit_block_allocator #(
    parameter int TABLE_ENTRIES = ffba_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // tdata: req_type[1:0], req_size[33:2], req_alignment[50:34],
    // free_address[90:51], zero fill above.
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [ffba_pkg::IN_W-1:0]       s_axis_tdata,
    // tdata: status[1:0], block_address[41:2], reserved_bytes[74:42],
    // peak_reserved_bytes[107:75], zero fill above.
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [ffba_pkg::OUT_W-1:0]      m_axis_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ffba_pkg::ADDR_W-1:0]     cfg_data
);
    import ffba_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = $bits(entry_t);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RND    = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_CHK    = 4'd3;
    localparam logic [3:0] S_SPLIT  = 4'd4;
    localparam logic [3:0] S_SO_LD  = 4'd5;
    localparam logic [3:0] S_SO_KEY = 4'd6;
    localparam logic [3:0] S_SO_CMP = 4'd7;
    localparam logic [3:0] S_SO_PUT = 4'd8;
    localparam logic [3:0] S_MG_0   = 4'd9;
    localparam logic [3:0] S_MG_RD  = 4'd10;
    localparam logic [3:0] S_MG_CHK = 4'd11;
    localparam logic [3:0] S_RESP   = 4'd12;

    logic [3:0]          state_reg, state_next;
    logic [TYPE_W-1:0]   op_reg, op_next;
    logic [RND_W-1:0]    rounded_reg, rounded_next;
    logic [ADDR_W-1:0]   faddr_reg, faddr_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [CW-1:0]       w_reg, w_next;
    entry_t              key_reg, key_next;
    entry_t              cur_reg, cur_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [OFF_W-1:0]    reserved_reg, reserved_next;
    logic [OFF_W-1:0]    peak_reg, peak_next;
    logic [ADDR_W-1:0]   base_reg;
    logic [OFF_W-1:0]    cap_reg;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    out_data_reg, out_data_next;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    entry_t              ram_wdata, rd;
    logic [EW-1:0]       ram_rdata;

    logic                rnd_start, rnd_done;
    logic [RND_W-1:0]    rnd_value;

    logic [TYPE_W-1:0]   in_type;
    logic [SIZE_W-1:0]   in_size;
    logic [ALIGN_W-1:0]  in_align;
    logic [ADDR_W-1:0]   in_faddr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [OFF_W+1:0]    fresh_sum;
    logic [OFF_W-1:0]    peak_new;
    logic                table_full;

    assign in_type  = s_axis_tdata[1:0];
    assign in_size  = s_axis_tdata[33:2];
    assign in_align = s_axis_tdata[50:34];
    assign in_faddr = s_axis_tdata[90:51];

    assign rd         = entry_t'(ram_rdata);
    assign rd_addr    = base_reg + ADDR_W'(rd.offset);
    assign fresh_sum  = (OFF_W+2)'(reserved_reg) + (OFF_W+2)'(rounded_reg);
    assign peak_new   = (reserved_reg > peak_reg) ? reserved_reg : peak_reg;
    assign table_full = count_reg >= CW'(TABLE_ENTRIES);

    ffba_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ffba_round u_round (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (rnd_start),
        .size    (in_size),
        .align   (in_align),
        .done    (rnd_done),
        .rounded (rnd_value)
    );

    // Request sequencer.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        rounded_next   = rounded_reg;
        faddr_next     = faddr_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        w_next         = w_reg;
        key_next       = key_reg;
        cur_next       = cur_reg;
        status_next    = status_reg;
        addr_next      = addr_reg;
        reserved_next  = reserved_reg;
        peak_next      = peak_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = rd;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        rnd_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next     = in_type;
                    faddr_next  = in_faddr;
                    addr_next   = '0;
                    status_next = ST_OK;
                    idx_next    = '0;
                    if (in_type == REQ_ALLOC)
                    begin
                        if (in_size == '0)
                        begin
                            status_next = ST_ZERO;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            rnd_start  = 1'b1;
                            state_next = S_RND;
                        end
                    end
                    else if (in_type == REQ_FREE)
                    begin
                        if (in_faddr == '0)
                        begin
                            status_next = ST_ZERO;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (in_type == REQ_CLEAR)
                    begin
                        count_next    = '0;
                        reserved_next = '0;
                        state_next    = S_RESP;
                    end
                    else
                    begin
                        status_next = ST_ZERO;
                        state_next  = S_RESP;
                    end
                end
            end

            S_RND:
            begin
                if (rnd_done)
                begin
                    rounded_next = rnd_value;
                    state_next   = S_SCAN;
                end
            end

            // Walk the table in list order; handle the end of the list here.
            S_SCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    if (op_reg == REQ_FREE)
                    begin
                        status_next = ST_NOTFOUND;
                    end
                    else if (table_full || fresh_sum > (OFF_W+2)'(cap_reg))
                    begin
                        status_next = ST_NOSPACE;
                    end
                    else
                    begin
                        ram_we           = 1'b1;
                        ram_waddr        = count_reg[AW-1:0];
                        ram_wdata.offset = reserved_reg;
                        ram_wdata.length = rounded_reg[OFF_W-1:0];
                        ram_wdata.is_free = 1'b0;
                        count_next       = count_reg + CW'(1);
                        addr_next        = base_reg + ADDR_W'(reserved_reg);
                        reserved_next    = fresh_sum[OFF_W-1:0];
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_reg[AW-1:0];
                    state_next = S_CHK;
                end
            end

            S_CHK:
            begin
                state_next = S_SCAN;
                idx_next   = idx_reg + CW'(1);
                if (op_reg == REQ_FREE)
                begin
                    if (rd_addr == faddr_reg)
                    begin
                        ram_we            = 1'b1;
                        ram_waddr         = idx_reg[AW-1:0];
                        ram_wdata.is_free = 1'b1;
                        idx_next          = CW'(1);
                        state_next        = S_SO_LD;
                    end
                end
                else if (rd.is_free && RND_W'(rd.length) >= rounded_reg)
                begin
                    ram_we            = 1'b1;
                    ram_waddr         = idx_reg[AW-1:0];
                    ram_wdata.is_free = 1'b0;
                    key_next          = rd;
                    addr_next         = rd_addr;
                    state_next        = S_RESP;
                    if ((RND_W+1)'(rd.length) > {rounded_reg, 1'b0} && !table_full)
                    begin
                        ram_wdata.length = rounded_reg[OFF_W-1:0];
                        state_next       = S_SPLIT;
                    end
                end
            end

            // Append the remainder of a split block as a free entry.
            S_SPLIT:
            begin
                ram_we            = 1'b1;
                ram_waddr         = count_reg[AW-1:0];
                ram_wdata.offset  = key_reg.offset + rounded_reg[OFF_W-1:0];
                ram_wdata.length  = key_reg.length - rounded_reg[OFF_W-1:0];
                ram_wdata.is_free = 1'b1;
                count_next        = count_reg + CW'(1);
                state_next        = S_RESP;
            end

            // Insertion sort by offset; idx_reg is the entry being inserted.
            S_SO_LD:
            begin
                if (idx_reg >= count_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    idx_next   = CW'(1);
                    w_next     = '0;
                    state_next = S_MG_0;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_reg[AW-1:0];
                    state_next = S_SO_KEY;
                end
            end

            S_SO_KEY:
            begin
                key_next   = rd;
                j_next     = idx_reg;
                ram_re     = 1'b1;
                ram_raddr  = AW'(idx_reg - CW'(1));
                state_next = S_SO_CMP;
            end

            S_SO_CMP:
            begin
                ram_we = 1'b1;
                if (rd.offset > key_reg.offset)
                begin
                    ram_waddr = j_reg[AW-1:0];
                    ram_wdata = rd;
                    j_next    = j_reg - CW'(1);
                    if (j_reg == CW'(1))
                    begin
                        state_next = S_SO_PUT;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(j_reg - CW'(2));
                    end
                end
                else
                begin
                    ram_waddr  = j_reg[AW-1:0];
                    ram_wdata  = key_reg;
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_SO_LD;
                end
            end

            S_SO_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = key_reg;
                idx_next   = idx_reg + CW'(1);
                state_next = S_SO_LD;
            end

            // Merge walk: cur_reg accumulates runs of adjacent free blocks.
            S_MG_0:
            begin
                cur_next   = rd;
                state_next = S_MG_RD;
            end

            S_MG_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = w_reg[AW-1:0];
                    ram_wdata  = cur_reg;
                    count_next = w_reg + CW'(1);
                    state_next = S_RESP;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_reg[AW-1:0];
                    state_next = S_MG_CHK;
                end
            end

            S_MG_CHK:
            begin
                idx_next   = idx_reg + CW'(1);
                state_next = S_MG_RD;
                if (cur_reg.is_free && rd.is_free &&
                    (cur_reg.offset + cur_reg.length) == rd.offset)
                begin
                    cur_next.length = cur_reg.length + rd.length;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = w_reg[AW-1:0];
                    ram_wdata = cur_reg;
                    w_next    = w_reg + CW'(1);
                    cur_next  = rd;
                end
            end

            // Load the result word once the output register is free.
            S_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = OUT_W'({peak_new, reserved_reg, addr_reg, status_reg});
                    out_valid_next = 1'b1;
                    peak_next      = peak_new;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            reserved_reg  <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
            base_reg      <= REGION_BASE_RST;
            cap_reg       <= POOL_CAP_RST;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            reserved_reg  <= reserved_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == CFG_REGION_BASE)
            begin
                base_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_POOL_CAP)
            begin
                cap_reg <= cfg_data[OFF_W-1:0];
            end
        end
    end

    // Working payload.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        rounded_reg  <= rounded_next;
        faddr_reg    <= faddr_next;
        idx_reg      <= idx_next;
        j_reg        <= j_next;
        w_reg        <= w_next;
        key_reg      <= key_next;
        cur_reg      <= cur_next;
        status_reg   <= status_next;
        addr_reg     <= addr_next;
        out_data_reg <= out_data_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `FFBA_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(TABLE_ENTRIES), "table count overflow")
    `FFBA_ASSERT_ALWAYS(a_peak_covers, (state_reg != S_IDLE) || (peak_reg >= reserved_reg), "peak below reserved total")
    `FFBA_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, state_reg != S_IDLE, "request accepted without work")

endmodule
`default_nettype wire
